FILE: rtl/pfbe_pkg.sv
// Package for the page frame buffer engine: field widths, codes, states and defaults.
package pfbe_pkg;

    localparam int COLUMNS_DEF = 128;
    localparam int PAGES_DEF   = 8;

    localparam int OP_W   = 2;
    localparam int X_W    = 7;
    localparam int Y_W    = 6;
    localparam int PG_W   = 3;
    localparam int DATA_W = 8;

    localparam int IN_W  = 32;
    localparam int OUT_W = 16;

    localparam logic [OP_W-1:0] OP_POINT = 2'd0;
    localparam logic [OP_W-1:0] OP_RECT  = 2'd1;
    localparam logic [OP_W-1:0] OP_READ  = 2'd2;

    localparam logic ST_DONE   = 1'b0;
    localparam logic ST_REJECT = 1'b1;

    localparam logic [DATA_W-1:0] BYTE_ONES  = 8'hFF;
    localparam logic [DATA_W-1:0] BYTE_ZERO  = 8'h00;
    localparam logic [DATA_W-1:0] BYTE_ONE   = 8'h01;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_MOD,
        S_RECT,
        S_DRAIN,
        S_FIN
    } t_state;

endpackage

FILE: rtl/page_frame_buffer_engine.sv
// Page-organized monochrome frame store with point draw, rectangle clear and byte read.
//
//   Channel   Direction  Beat contents (lowest bit first)
//   s (in)    slave      operation, x_start, y_start, x_end, y_end, pixel_on, read_page
//   m (out)   master     read_data, status, zero fill to 16 bits
//
// For point and read items the accept cycle issues the memory read and the next cycle
// writes back and loads the output register if it is free, else the result waits in S_FIN.
// A rectangle clear steps in S_RECT through the covered entries, column by column in each
// page, then passes S_DRAIN and S_FIN; the one read and one write port do each update.
// After reset the block sweeps all COLUMNS*PAGES entries of the memory to zero, one entry
// a cycle, with s_tready low.
// An item is accepted while an earlier result still waits in the output register; the
// result of the new item waits for that register to empty.
module page_frame_buffer_engine
    import pfbe_pkg::*;
#(
    parameter int COLUMNS = COLUMNS_DEF,
    parameter int PAGES   = PAGES_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_tvalid,
    output logic             o_s_tready,
    // operation[1:0], x_start[8:2], y_start[14:9], x_end[21:15], y_end[27:22],
    // pixel_on[28], read_page[31:29]
    input  logic [IN_W-1:0]  i_s_tdata,
    output logic             o_m_tvalid,
    input  logic             i_m_tready,
    // read_data[7:0], status[8], zero [15:9]
    output logic [OUT_W-1:0] o_m_tdata
);

    localparam int DEPTH = COLUMNS * PAGES;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_mem_q;

    t_state r_state, n_state;
    logic [AW-1:0]     r_clr, n_clr;
    logic [OP_W-1:0]   r_op, n_op;
    logic              r_on, n_on;
    logic              r_hit, n_hit;
    logic [2:0]        r_bit, n_bit;
    logic [AW-1:0]     r_addr, n_addr;
    logic [X_W-1:0]    r_col, n_col;
    logic [X_W-1:0]    r_x0, n_x0;
    logic [X_W-1:0]    r_xl, n_xl;
    logic [PG_W-1:0]   r_page, n_page;
    logic [PG_W-1:0]   r_p0, n_p0;
    logic [PG_W-1:0]   r_p1, n_p1;
    logic [PG_W-1:0]   r_pl, n_pl;
    logic [2:0]        r_y0lo, n_y0lo;
    logic [2:0]        r_y1lo, n_y1lo;
    logic              r_wv, n_wv;
    logic [AW-1:0]     r_waddr, n_waddr;
    logic [DATA_W-1:0] r_wmask, n_wmask;
    logic [DATA_W-1:0] r_res_data, n_res_data;
    logic              r_res_status, n_res_status;
    logic              r_ovalid, n_ovalid;
    logic [DATA_W-1:0] r_odata, n_odata;
    logic              r_ostatus, n_ostatus;

    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [DATA_W-1:0] mem_wdata;
    logic [AW-1:0]     mem_raddr;

    logic [OP_W-1:0]   in_op;
    logic [X_W-1:0]    in_xs, in_xe;
    logic [Y_W-1:0]    in_ys, in_ye;
    logic              in_on;
    logic [PG_W-1:0]   in_rp;
    logic              accept;
    logic              out_free;
    logic [DATA_W-1:0] top_mask, bot_mask, cur_mask, bit_mask;
    logic [DATA_W-1:0] mod_data;

    function automatic logic col_ok(input logic [X_W-1:0] col);
        return int'(col) < COLUMNS;
    endfunction

    function automatic logic page_ok(input logic [PG_W-1:0] page);
        return int'(page) < PAGES;
    endfunction

    function automatic logic [AW-1:0] entry(input logic [X_W-1:0] col,
                                            input logic [PG_W-1:0] page);
        int idx;
        idx = int'(col) * PAGES + int'(page);
        return AW'(idx);
    endfunction

    assign in_op = i_s_tdata[1:0];
    assign in_xs = i_s_tdata[8:2];
    assign in_ys = i_s_tdata[14:9];
    assign in_xe = i_s_tdata[21:15];
    assign in_ye = i_s_tdata[27:22];
    assign in_on = i_s_tdata[28];
    assign in_rp = i_s_tdata[31:29];

    assign o_s_tready = (r_state == S_IDLE);
    assign accept     = i_s_tvalid && o_s_tready;
    assign out_free   = !r_ovalid || i_m_tready;

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = {{(OUT_W - DATA_W - 1){1'b0}}, r_ostatus, r_odata};

    assign top_mask = BYTE_ONES << r_y0lo;
    assign bot_mask = BYTE_ONES >> (3'd7 - r_y1lo);
    assign bit_mask = BYTE_ONE << r_bit;
    assign mod_data = r_on ? (r_mem_q | bit_mask) : (r_mem_q & ~bit_mask);

    always_comb begin
        cur_mask = BYTE_ONES;
        if (r_page == r_p0) begin
            cur_mask = cur_mask & top_mask;
        end
        if (r_page == r_p1) begin
            cur_mask = cur_mask & bot_mask;
        end
    end

    always_comb begin
        n_state      = r_state;
        n_clr        = r_clr;
        n_op         = r_op;
        n_on         = r_on;
        n_hit        = r_hit;
        n_bit        = r_bit;
        n_addr       = r_addr;
        n_col        = r_col;
        n_x0         = r_x0;
        n_xl         = r_xl;
        n_page       = r_page;
        n_p0         = r_p0;
        n_p1         = r_p1;
        n_pl         = r_pl;
        n_y0lo       = r_y0lo;
        n_y1lo       = r_y1lo;
        n_wv         = 1'b0;
        n_waddr      = r_waddr;
        n_wmask      = r_wmask;
        n_res_data   = r_res_data;
        n_res_status = r_res_status;
        n_ovalid     = r_ovalid && !i_m_tready;
        n_odata      = r_odata;
        n_ostatus    = r_ostatus;
        mem_we       = 1'b0;
        mem_waddr    = r_waddr;
        mem_wdata    = r_mem_q & ~r_wmask;
        mem_raddr    = r_addr;

        if (r_wv) begin
            mem_we = 1'b1;
        end

        unique case (r_state)
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr;
                mem_wdata = BYTE_ZERO;
                n_clr     = r_clr + 1'b1;
                if (r_clr == AW'(DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    n_op         = in_op;
                    n_on         = in_on;
                    n_bit        = in_ys[2:0];
                    n_res_data   = BYTE_ZERO;
                    n_res_status = ST_DONE;
                    unique case (in_op)
                        OP_POINT: begin
                            n_hit     = col_ok(in_xs) && page_ok(in_ys[5:3]);
                            n_addr    = entry(in_xs, in_ys[5:3]);
                            mem_raddr = n_addr;
                            n_state   = S_MOD;
                        end
                        OP_READ: begin
                            n_hit     = col_ok(in_xs) && page_ok(in_rp);
                            n_addr    = entry(in_xs, in_rp);
                            mem_raddr = n_addr;
                            n_state   = S_MOD;
                        end
                        OP_RECT: begin
                            n_x0   = in_xs;
                            n_col  = in_xs;
                            n_xl   = col_ok(in_xe) ? in_xe : X_W'(COLUMNS - 1);
                            n_p0   = in_ys[5:3];
                            n_page = in_ys[5:3];
                            n_p1   = in_ye[5:3];
                            n_pl   = page_ok(in_ye[5:3]) ? in_ye[5:3] : PG_W'(PAGES - 1);
                            n_y0lo = in_ys[2:0];
                            n_y1lo = in_ye[2:0];
                            if (in_xs > in_xe || in_ys > in_ye) begin
                                n_res_status = ST_REJECT;
                                n_state      = S_FIN;
                            end else if (!col_ok(in_xs) || !page_ok(in_ys[5:3])) begin
                                n_state = S_FIN;
                            end else begin
                                n_state = S_RECT;
                            end
                        end
                        default: begin
                            n_state = S_FIN;
                        end
                    endcase
                end
            end
            S_MOD: begin
                if (r_op == OP_POINT && r_hit) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_addr;
                    mem_wdata = mod_data;
                end
                n_res_data = (r_op == OP_READ && r_hit) ? r_mem_q : BYTE_ZERO;
                if (out_free) begin
                    n_ovalid  = 1'b1;
                    n_odata   = n_res_data;
                    n_ostatus = r_res_status;
                    n_state   = S_IDLE;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_RECT: begin
                mem_raddr = entry(r_col, r_page);
                n_wv      = 1'b1;
                n_waddr   = mem_raddr;
                n_wmask   = cur_mask;
                if (r_col == r_xl) begin
                    n_col = r_x0;
                    if (r_page == r_pl) begin
                        n_state = S_DRAIN;
                    end else begin
                        n_page = r_page + 1'b1;
                    end
                end else begin
                    n_col = r_col + 1'b1;
                end
            end
            S_DRAIN: begin
                n_state = S_FIN;
            end
            S_FIN: begin
                if (out_free) begin
                    n_ovalid  = 1'b1;
                    n_odata   = r_res_data;
                    n_ostatus = r_res_status;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_mem_q <= r_mem[mem_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_clr    <= '0;
            r_wv     <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_clr    <= n_clr;
            r_wv     <= n_wv;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op         <= n_op;
        r_on         <= n_on;
        r_hit        <= n_hit;
        r_bit        <= n_bit;
        r_addr       <= n_addr;
        r_col        <= n_col;
        r_x0         <= n_x0;
        r_xl         <= n_xl;
        r_page       <= n_page;
        r_p0         <= n_p0;
        r_p1         <= n_p1;
        r_pl         <= n_pl;
        r_y0lo       <= n_y0lo;
        r_y1lo       <= n_y1lo;
        r_waddr      <= n_waddr;
        r_wmask      <= n_wmask;
        r_res_data   <= n_res_data;
        r_res_status <= n_res_status;
        r_odata      <= n_odata;
        r_ostatus    <= n_ostatus;
    end

endmodule

FILE: rtl/pfbe_checker.sv
// Port-level checker for the page frame buffer engine and its bind statement.
module pfbe_checker
    import pfbe_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_s_tvalid,
    input logic             o_s_tready,
    input logic [IN_W-1:0]  i_s_tdata,
    input logic             o_m_tvalid,
    input logic             i_m_tready,
    input logic [OUT_W-1:0] o_m_tdata
);

    // No result beat may follow reset.
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result beat shown right after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("stalled result beat changed");

    // Only one item is in work at a time.
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("second beat accepted while an item is in work");

    // A rejected rectangle never carries data, and the fill bits stay zero.
    a_reject_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[OUT_W-1:DATA_W+1] == '0) &&
                       (!o_m_tdata[DATA_W] || (o_m_tdata[DATA_W-1:0] == BYTE_ZERO)))
        else $error("rejected result carries data or fill bits are set");

endmodule

bind page_frame_buffer_engine pfbe_checker u_pfbe_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .i_s_tdata  (i_s_tdata),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);

FILE: tb/sv/page_frame_buffer_engine_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for the page frame buffer engine with draw, clear and read beats.
module page_frame_buffer_engine_test;
    import pfbe_pkg::*;

    localparam int NUM_COLS      = COLUMNS_DEF;
    localparam int NUM_PAGES     = PAGES_DEF;
    localparam int RANDOM_CMDS   = 950;
    localparam int IDLE_LIMIT    = 12000;
    localparam int SETTLE_CYCLES = 40;
    localparam logic [OP_W-1:0] OP_SPARE = 2'd3;

    typedef struct {
        logic [OP_W-1:0] op;
        logic [X_W-1:0]  xs;
        logic [Y_W-1:0]  ys;
        logic [X_W-1:0]  xe;
        logic [Y_W-1:0]  ye;
        logic            on;
        logic [PG_W-1:0] pg;
        bit              drain_first;
    } t_fb_cmd;

    typedef struct {
        logic [DATA_W-1:0] data;
        logic              status;
    } t_fb_result;

    logic              i_clk    = 1'b0;
    logic              rst_n    = 1'b0;
    logic              s_tvalid = 1'b0;
    logic [IN_W-1:0]   s_tdata  = '0;
    logic              m_tready = 1'b0;
    logic              o_s_tready;
    logic              o_m_tvalid;
    logic [OUT_W-1:0]  o_m_tdata;

    logic [DATA_W-1:0] frame_bytes [NUM_COLS][NUM_PAGES];
    t_fb_cmd           cmd_q[$];
    t_fb_result        awaited_results[$];
    t_fb_cmd           cur_cmd;
    int                mismatch_count = 0;
    int                result_count   = 0;
    int                gap_left       = 0;
    int                burst_left     = 1;
    int                ready_run      = 0;
    int                idle_cycles    = 0;

    page_frame_buffer_engine dut (
        .i_clk     (i_clk),
        .i_rst_n   (rst_n),
        .i_s_tvalid(s_tvalid),
        .o_s_tready(o_s_tready),
        // operation, x_start, y_start, x_end, y_end, pixel_on, read_page
        .i_s_tdata (s_tdata),
        .o_m_tvalid(o_m_tvalid),
        .i_m_tready(m_tready),
        // read_data, status, zero fill
        .o_m_tdata (o_m_tdata)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic t_fb_cmd make_cmd(logic [OP_W-1:0] op, int xs, int ys, int xe, int ye,
                                         bit on, int pg);
        t_fb_cmd c;
        c.op = op;
        c.xs = X_W'(xs);
        c.ys = Y_W'(ys);
        c.xe = X_W'(xe);
        c.ye = Y_W'(ye);
        c.on = on;
        c.pg = PG_W'(pg);
        c.drain_first = 1'b0;
        return c;
    endfunction

    function automatic t_fb_cmd random_cmd(int hot_x);
        t_fb_cmd c;
        int pick;
        int near_x;
        int tmp;
        pick = $urandom_range(0, 99);
        near_x = hot_x + $urandom_range(0, 7);
        c.op = OP_SPARE;
        c.xs = X_W'($urandom);
        c.ys = Y_W'($urandom);
        c.xe = X_W'($urandom);
        c.ye = Y_W'($urandom);
        c.on = 1'($urandom);
        c.pg = PG_W'($urandom);
        c.drain_first = 1'b0;
        if (pick < 45) begin
            c.op = OP_POINT;
            c.on = ($urandom_range(0, 4) != 0);
            if ($urandom_range(0, 3) != 0) c.xs = X_W'(near_x);
        end else if (pick < 75) begin
            c.op = OP_READ;
            if ($urandom_range(0, 3) != 0) c.xs = X_W'(near_x);
        end else if (pick < 96) begin
            c.op = OP_RECT;
            if ($urandom_range(0, 29) == 0) begin
                c.xs = X_W'($urandom_range(0, 3));
                c.xe = X_W'($urandom_range(124, 127));
                c.ys = Y_W'($urandom_range(0, 7));
                c.ye = Y_W'($urandom_range(56, 63));
            end else if ($urandom_range(0, 7) != 0) begin
                c.xs = X_W'(near_x);
                tmp = near_x + $urandom_range(0, 8);
                c.xe = X_W'((tmp > NUM_COLS - 1) ? NUM_COLS - 1 : tmp);
                tmp = c.ys + $urandom_range(0, 12);
                c.ye = Y_W'((tmp > 63) ? 63 : tmp);
            end
        end
        return c;
    endfunction

    function automatic t_fb_result apply_to_frame(t_fb_cmd c);
        t_fb_result r;
        logic [DATA_W-1:0] mask;
        int p0;
        int p1;
        r.data = BYTE_ZERO;
        r.status = ST_DONE;
        case (c.op)
            OP_POINT: begin
                if (c.xs < NUM_COLS && (int'(c.ys) >> 3) < NUM_PAGES) begin
                    mask = BYTE_ONE << c.ys[2:0];
                    if (c.on)
                        frame_bytes[c.xs][c.ys >> 3] = frame_bytes[c.xs][c.ys >> 3] | mask;
                    else
                        frame_bytes[c.xs][c.ys >> 3] = frame_bytes[c.xs][c.ys >> 3] & ~mask;
                end
            end
            OP_RECT: begin
                if (c.xs > c.xe || c.ys > c.ye) begin
                    r.status = ST_REJECT;
                end else begin
                    p0 = int'(c.ys) >> 3;
                    p1 = int'(c.ye) >> 3;
                    for (int p = p0; p <= p1; p++) begin
                        mask = BYTE_ONES;
                        if (p == p0) mask = mask & (BYTE_ONES << c.ys[2:0]);
                        if (p == p1) mask = mask & (BYTE_ONES >> (3'd7 - c.ye[2:0]));
                        for (int x = c.xs; x <= c.xe; x++) begin
                            if (x < NUM_COLS && p < NUM_PAGES)
                                frame_bytes[x][p] = frame_bytes[x][p] & ~mask;
                        end
                    end
                end
            end
            OP_READ: begin
                if (c.xs < NUM_COLS && c.pg < NUM_PAGES) r.data = frame_bytes[c.xs][c.pg];
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic report_mismatch(string what);
        $display("mismatch at %0t ns: %s", $time, what);
        mismatch_count++;
    endtask

    always @(posedge i_clk) begin : driver
        t_fb_cmd next_cmd;
        if (!rst_n) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && o_s_tready) awaited_results.push_back(apply_to_frame(cur_cmd));
            if (!s_tvalid || o_s_tready) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    s_tvalid <= 1'b0;
                end else if (cmd_q.size() > 0 &&
                             !(cmd_q[0].drain_first && awaited_results.size() > 0)) begin
                    next_cmd = cmd_q.pop_front();
                    cur_cmd  <= next_cmd;
                    s_tdata  <= {next_cmd.pg, next_cmd.on, next_cmd.ye, next_cmd.xe,
                                 next_cmd.ys, next_cmd.xs, next_cmd.op};
                    s_tvalid <= 1'b1;
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 40);
                        gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (ready_run == 0) begin
            m_tready  <= !m_tready;
            ready_run <= m_tready ? $urandom_range(1, 12) :
                         (($urandom_range(0, 3) == 0) ? $urandom_range(40, 120) :
                                                         $urandom_range(0, 8));
        end else begin
            ready_run <= ready_run - 1;
        end
    end

    always @(posedge i_clk) begin : monitor
        t_fb_result oldest;
        if (rst_n && o_m_tvalid && m_tready) begin
            if (awaited_results.size() == 0) begin
                report_mismatch($sformatf("result beat %0d with nothing pending, data %0h",
                                          result_count, o_m_tdata));
            end else begin
                oldest = awaited_results.pop_front();
                if (o_m_tdata[DATA_W-1:0] !== oldest.data)
                    report_mismatch($sformatf("beat %0d read_data %0h, want %0h", result_count,
                                              o_m_tdata[DATA_W-1:0], oldest.data));
                if (o_m_tdata[DATA_W] !== oldest.status)
                    report_mismatch($sformatf("beat %0d status %0b, want %0b", result_count,
                                              o_m_tdata[DATA_W], oldest.status));
                if (o_m_tdata[OUT_W-1:DATA_W+1] !== '0)
                    report_mismatch($sformatf("beat %0d fill bits %0h, want 0", result_count,
                                              o_m_tdata[OUT_W-1:DATA_W+1]));
            end
            result_count++;
        end
    end

    always @(posedge i_clk) begin
        if (!rst_n || (s_tvalid && o_s_tready) || (o_m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("[page_frame_buffer_engine] ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : stimulus
        t_fb_cmd c;
        int hot_x;
        foreach (frame_bytes[x, p]) frame_bytes[x][p] = BYTE_ZERO;

        cmd_q.push_back(make_cmd(OP_READ, 0, 0, 0, 0, 0, 0));
        cmd_q.push_back(make_cmd(OP_READ, 127, 0, 0, 0, 0, 7));
        cmd_q.push_back(make_cmd(OP_POINT, 0, 0, 0, 0, 1, 0));
        cmd_q.push_back(make_cmd(OP_POINT, 127, 63, 0, 0, 1, 0));
        cmd_q.push_back(make_cmd(OP_READ, 0, 0, 0, 0, 0, 0));
        cmd_q.push_back(make_cmd(OP_READ, 127, 0, 0, 0, 0, 7));
        cmd_q.push_back(make_cmd(OP_POINT, 127, 63, 0, 0, 0, 0));
        cmd_q.push_back(make_cmd(OP_READ, 127, 0, 0, 0, 0, 7));
        cmd_q.push_back(make_cmd(OP_POINT, 10, 8, 0, 0, 1, 0));
        cmd_q.push_back(make_cmd(OP_POINT, 10, 10, 0, 0, 1, 0));
        cmd_q.push_back(make_cmd(OP_POINT, 10, 12, 0, 0, 1, 0));
        cmd_q.push_back(make_cmd(OP_POINT, 10, 13, 0, 0, 1, 0));
        cmd_q.push_back(make_cmd(OP_POINT, 10, 15, 0, 0, 1, 0));
        // Both edges on one page at different offsets: only the band between them goes.
        cmd_q.push_back(make_cmd(OP_RECT, 10, 10, 10, 13, 0, 0));
        cmd_q.push_back(make_cmd(OP_READ, 10, 0, 0, 0, 0, 1));
        cmd_q.push_back(make_cmd(OP_RECT, 20, 0, 10, 63, 0, 0));
        cmd_q.push_back(make_cmd(OP_RECT, 0, 40, 127, 30, 0, 0));
        cmd_q.push_back(make_cmd(OP_POINT, 64, 31, 0, 0, 1, 0));
        cmd_q.push_back(make_cmd(OP_POINT, 64, 30, 0, 0, 1, 0));
        cmd_q.push_back(make_cmd(OP_POINT, 64, 32, 0, 0, 1, 0));
        cmd_q.push_back(make_cmd(OP_RECT, 60, 31, 70, 32, 0, 0));
        cmd_q.push_back(make_cmd(OP_READ, 64, 0, 0, 0, 0, 3));
        cmd_q.push_back(make_cmd(OP_RECT, 0, 0, 127, 63, 0, 0));
        cmd_q.push_back(make_cmd(OP_READ, 64, 0, 0, 0, 0, 3));
        cmd_q.push_back(make_cmd(OP_SPARE, 127, 63, 127, 63, 1, 7));

        hot_x = $urandom_range(0, 120);
        for (int n = 0; n < RANDOM_CMDS; n++) begin
            if (n % 40 == 0) hot_x = $urandom_range(0, 120);
            c = random_cmd(hot_x);
            if (n % 250 == 0) c.drain_first = 1'b1;
            cmd_q.push_back(c);
        end

        repeat (12) @(posedge i_clk);
        rst_n <= 1'b1;

        while (cmd_q.size() > 0 || s_tvalid) @(posedge i_clk);
        while (awaited_results.size() > 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0)
            $display("[page_frame_buffer_engine] OK");
        else
            $display("[page_frame_buffer_engine] ERROR");
        $finish;
    end

endmodule
